@@ hw/rtl/rbca_pkg.sv @@
// Shared constants, types and pointer arithmetic of the commit/ack byte ring buffer.
package rbca_pkg;

	localparam int LARGE_DEPTH = 1024;
	localparam int SMALL_DEPTH = 256;
	localparam int MAX_DEPTH   = (LARGE_DEPTH > SMALL_DEPTH) ? LARGE_DEPTH : SMALL_DEPTH;

	localparam int BYTE_W  = 8;
	localparam int FIELD_W = 10;
	localparam int PTR_W   = $clog2(MAX_DEPTH);
	localparam int DEP_W   = $clog2(MAX_DEPTH + 1);
	// wide enough for pointer plus two field values
	localparam int SUM_W   = ((PTR_W > FIELD_W) ? PTR_W : FIELD_W) + 2;

	localparam logic [DEP_W-1:0] LARGE_D = DEP_W'(LARGE_DEPTH);
	localparam logic [DEP_W-1:0] SMALL_D = DEP_W'(SMALL_DEPTH);

	typedef enum logic [2:0] {
		CMD_WRITE      = 3'd0,
		CMD_READ       = 3'd1,
		CMD_PEEK_CM    = 3'd2,
		CMD_ACK        = 3'd3,
		CMD_COMMIT_ALL = 3'd4,
		CMD_COMMIT_LEN = 3'd5,
		CMD_PEEK_UNC   = 3'd6,
		CMD_RESET      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [BYTE_W-1:0]  data_in;
		logic [FIELD_W-1:0] start_offset;
		logic [FIELD_W-1:0] element_index;
		logic [FIELD_W-1:0] length;
	} item_t;

	typedef struct packed {
		logic               wr_en;
		logic [PTR_W-1:0]   wr_addr;
		logic [BYTE_W-1:0]  wr_data;
		logic               rd_en;
		logic [PTR_W-1:0]   rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic               rd_hit;
		status_t            status;
		logic [FIELD_W-1:0] free_size;
		logic [FIELD_W-1:0] data_size;
		logic [FIELD_W-1:0] unread_size;
		logic [FIELD_W-1:0] block_length;
		logic [FIELD_W-1:0] shortfall;
	} res_t;

	// one conditional subtract: valid while s < 2*d
	function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] s,
	                                              input logic [DEP_W-1:0] d);
		logic [SUM_W-1:0] t;
		t = (s >= SUM_W'(d)) ? (s - SUM_W'(d)) : s;
		return t[PTR_W-1:0];
	endfunction

	// (a - b) mod d for a, b below d
	function automatic logic [DEP_W-1:0] span(input logic [PTR_W-1:0] a,
	                                          input logic [PTR_W-1:0] b,
	                                          input logic [DEP_W-1:0] d);
		logic [SUM_W-1:0] t;
		if (a >= b)
			t = SUM_W'(a) - SUM_W'(b);
		else
			t = SUM_W'(a) + SUM_W'(d) - SUM_W'(b);
		return t[DEP_W-1:0];
	endfunction

endpackage

@@ hw/rtl/rbca_if.sv @@
// Valid/ready channel interfaces for commands and results.
interface rbca_req_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     cmd;
	logic [rbca_pkg::BYTE_W-1:0]    data_in;
	logic [rbca_pkg::FIELD_W-1:0]   start_offset;
	logic [rbca_pkg::FIELD_W-1:0]   element_index;
	logic [rbca_pkg::FIELD_W-1:0]   length;

	modport source (output valid, cmd, data_in, start_offset, element_index, length,
	                input ready);
	modport sink   (input valid, cmd, data_in, start_offset, element_index, length,
	                output ready);
endinterface

interface rbca_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rbca_pkg::BYTE_W-1:0]    read_byte;
	logic [1:0]                     status;
	logic [rbca_pkg::FIELD_W-1:0]   free_size;
	logic [rbca_pkg::FIELD_W-1:0]   data_size;
	logic [rbca_pkg::FIELD_W-1:0]   unread_size;
	logic [rbca_pkg::FIELD_W-1:0]   block_length;
	logic [rbca_pkg::FIELD_W-1:0]   shortfall;

	modport source (output valid, read_byte, status, free_size, data_size, unread_size,
	                block_length, shortfall, input ready);
	modport sink   (input valid, read_byte, status, free_size, data_size, unread_size,
	                block_length, shortfall, output ready);
endinterface

@@ hw/rtl/rbca_store.sv @@
// Byte storage of the ring: one write port, one registered read port.
module rbca_store (
	input  logic                         clk,
	input  rbca_pkg::mem_req_t           req,
	output logic [rbca_pkg::BYTE_W-1:0]  rd_data
);
	import rbca_pkg::*;

	logic [BYTE_W-1:0] ring_q [MAX_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en)
			ring_q[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rd_data_q <= ring_q[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/rbca_ctrl.sv @@
// Pointer state, mode register and per-command decode of the ring buffer.
module rbca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                advance,
	input  rbca_pkg::item_t     item,
	output rbca_pkg::mem_req_t  mem_req,
	output rbca_pkg::res_t      res
);
	import rbca_pkg::*;

	logic [PTR_W-1:0] wr_ptr_q, cm_ptr_q, rd_ptr_q;
	logic             large_mode_q;

	logic [DEP_W-1:0] depth, held, committed, pending;
	logic [DEP_W-1:0] held_n, free_d, data_d, unread_d;
	logic [PTR_W-1:0] wr_n, cm_n, rd_n, rd_addr;
	logic [SUM_W-1:0] s_start, s_idx, s_len, s_depth, s_comm, s_pend;
	logic [SUM_W-1:0] s_wr, s_cm, s_rd, clamp, blk, sfall;
	logic             wr_ok, hit;
	status_t          st;

	// mode change folds each pointer into the new ring size
	function automatic logic [PTR_W-1:0] fold_ptr(input logic [PTR_W-1:0] p,
	                                              input logic sel_large);
		if (sel_large)
			return PTR_W'(p % LARGE_DEPTH);
		else
			return PTR_W'(p % SMALL_DEPTH);
	endfunction

	always_comb begin
		depth     = large_mode_q ? LARGE_D : SMALL_D;
		held      = span(wr_ptr_q, rd_ptr_q, depth);
		committed = span(cm_ptr_q, rd_ptr_q, depth);
		pending   = span(wr_ptr_q, cm_ptr_q, depth);

		s_start = SUM_W'(item.start_offset);
		s_idx   = SUM_W'(item.element_index);
		s_len   = SUM_W'(item.length);
		s_depth = SUM_W'(depth);
		s_comm  = SUM_W'(committed);
		s_pend  = SUM_W'(pending);
		s_wr    = SUM_W'(wr_ptr_q);
		s_cm    = SUM_W'(cm_ptr_q);
		s_rd    = SUM_W'(rd_ptr_q);
		clamp   = (s_len > s_pend) ? s_pend : s_len;

		wr_n    = wr_ptr_q;
		cm_n    = cm_ptr_q;
		rd_n    = rd_ptr_q;
		rd_addr = rd_ptr_q;
		st      = ST_OK;
		wr_ok   = 1'b0;
		hit     = 1'b0;
		blk     = '0;
		sfall   = '0;

		unique case (item.cmd)
			CMD_WRITE: begin
				if (SUM_W'(held) >= s_depth - SUM_W'(1)) begin
					st = ST_FULL;
				end else begin
					wr_ok = 1'b1;
					wr_n  = wrap_ptr(s_wr + SUM_W'(1), depth);
				end
			end
			CMD_READ: begin
				if (committed == '0) begin
					st = ST_SHORT;
				end else begin
					hit  = 1'b1;
					rd_n = wrap_ptr(s_rd + SUM_W'(1), depth);
				end
			end
			CMD_PEEK_CM: begin
				if (s_idx < s_len && s_start + s_len <= s_comm) begin
					hit     = 1'b1;
					rd_addr = wrap_ptr(s_rd + s_start + s_idx, depth);
				end else begin
					st = ST_SHORT;
				end
			end
			CMD_ACK: begin
				if (s_len <= s_comm)
					rd_n = wrap_ptr(s_rd + s_len, depth);
				else
					st = ST_SHORT;
			end
			CMD_COMMIT_ALL: begin
				cm_n = wr_ptr_q;
			end
			CMD_COMMIT_LEN: begin
				cm_n = wrap_ptr(s_cm + clamp, depth);
			end
			CMD_PEEK_UNC: begin
				if (s_len == '0) begin
					st = ST_SHORT;
				end else if (s_pend <= s_start) begin
					sfall = s_start - s_pend;
					st    = ST_SHORT;
				end else begin
					blk = ((s_pend - s_start) > s_len) ? s_len : (s_pend - s_start);
					if (s_idx < blk) begin
						hit     = 1'b1;
						rd_addr = wrap_ptr(s_cm + s_start + s_idx, depth);
					end else begin
						st = ST_SHORT;
					end
				end
			end
			CMD_RESET: begin
				wr_n = '0;
				cm_n = '0;
				rd_n = '0;
			end
		endcase

		held_n   = span(wr_n, rd_n, depth);
		free_d   = depth - DEP_W'(1) - held_n;
		data_d   = span(cm_n, rd_n, depth);
		unread_d = span(wr_n, cm_n, depth);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			cm_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			large_mode_q <= 1'b0;
		end else if (cfg_we) begin
			large_mode_q <= cfg_wdata;
			wr_ptr_q     <= fold_ptr(wr_ptr_q, cfg_wdata);
			cm_ptr_q     <= fold_ptr(cm_ptr_q, cfg_wdata);
			rd_ptr_q     <= fold_ptr(rd_ptr_q, cfg_wdata);
		end else if (advance) begin
			wr_ptr_q <= wr_n;
			cm_ptr_q <= cm_n;
			rd_ptr_q <= rd_n;
		end
	end

	assign mem_req.wr_en   = advance & wr_ok;
	assign mem_req.wr_addr = wr_ptr_q;
	assign mem_req.wr_data = item.data_in;
	assign mem_req.rd_en   = advance;
	assign mem_req.rd_addr = rd_addr;

	assign res.rd_hit       = hit;
	assign res.status       = st;
	assign res.free_size    = FIELD_W'(free_d);
	assign res.data_size    = FIELD_W'(data_d);
	assign res.unread_size  = FIELD_W'(unread_d);
	assign res.block_length = FIELD_W'(blk);
	assign res.shortfall    = FIELD_W'(sfall);

	// reported sizes never exceed the usable ring
	a_sizes_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (free_d < depth && data_d < depth && unread_d < depth))
		else $error("region size outside ring capacity");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		DEP_W'(wr_ptr_q) < depth && DEP_W'(cm_ptr_q) < depth && DEP_W'(rd_ptr_q) < depth)
		else $error("pointer outside selected ring size");

	a_write_gate: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (item.cmd == CMD_WRITE && st == ST_OK))
		else $error("store written by a dropped or non-write transaction");

endmodule

@@ hw/rtl/ring_buffer_with_commit_and_ack.sv @@
// Top level of the byte ring buffer with commit and acknowledge pointers.
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  ----------------------------------------------------
//  req      in   valid/ready   cmd, data_in, start_offset, element_index, length
//  rsp      out  valid/ready   read_byte, status, free_size, data_size, unread_size,
//                              block_length, shortfall
//  cfg      in   cfg_we        cfg_wdata -> large_mode (no read-back)
//
//  One transaction per clock while rsp is taken; a result passes the input register,
//  then pointer logic plus the store's registered read port.
//  Reset: pointers zero, small ring selected; store contents are left as they are.
//  A stalled rsp holds the result register and the input register; req.ready
//  drops only while both stages are full and rsp is not taken.
module ring_buffer_with_commit_and_ack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	rbca_req_if.sink    req,
	rbca_rsp_if.source  rsp
);
	import rbca_pkg::*;

	// stage 1: accepted command
	logic     valid_s1;
	item_t    item_s1;
	// stage 2: finished result, read byte comes from the store's read register
	logic     valid_s2;
	res_t     res_s2;

	logic              adv;
	mem_req_t          mem_req;
	res_t              res;
	logic [BYTE_W-1:0] rd_data;

	// stage 1 moves on whenever the result register is free or being drained
	assign adv       = valid_s1 & (~valid_s2 | rsp.ready);
	assign req.ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (~valid_s2 | rsp.ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready & req.valid) begin
			item_s1.cmd           <= cmd_t'(req.cmd);
			item_s1.data_in       <= req.data_in;
			item_s1.start_offset  <= req.start_offset;
			item_s1.element_index <= req.element_index;
			item_s1.length        <= req.length;
		end
		if (adv)
			res_s2 <= res;
	end

	rbca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (adv),
		.item      (item_s1),
		.mem_req   (mem_req),
		.res       (res)
	);

	rbca_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// byte only shows on a successful read or peek; zero otherwise
	assign rsp.valid        = valid_s2;
	assign rsp.read_byte    = res_s2.rd_hit ? rd_data : '0;
	assign rsp.status       = res_s2.status;
	assign rsp.free_size    = res_s2.free_size;
	assign rsp.data_size    = res_s2.data_size;
	assign rsp.unread_size  = res_s2.unread_size;
	assign rsp.block_length = res_s2.block_length;
	assign rsp.shortfall    = res_s2.shortfall;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 transaction lost while stalled");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && res_s2.status != ST_OK) |-> (rsp.read_byte == '0))
		else $error("nonzero byte on a failed transaction");

endmodule
